### sv/key_event_to_utf8_bytes_macros.svh
// Assertion helpers shared by the converter modules.
// They expect signals named clock and reset in the scope where they are used.
`ifndef KEY_EVENT_TO_UTF8_BYTES_MACROS_SVH
`define KEY_EVENT_TO_UTF8_BYTES_MACROS_SVH

// The condition holds at every edge outside reset.
`define KE_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("key event converter: invariant violated");

// The consequent holds in the cycle after the antecedent.
`define KE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("key event converter: sequence violated");

`endif

### sv/ke2u8_pkg.sv
package ke2u8_pkg;

   // Virtual key codes that bypass the code unit.
   localparam logic [7:0] HOME_VKEY   = 8'h24;
   localparam logic [7:0] LEFT_VKEY   = 8'h25;
   localparam logic [7:0] UP_VKEY     = 8'h26;
   localparam logic [7:0] RIGHT_VKEY  = 8'h27;
   localparam logic [7:0] DOWN_VKEY   = 8'h28;
   localparam logic [7:0] DELETE_VKEY = 8'h2E;

   localparam logic [15:0] CHAR_A = 16'h0041;
   localparam logic [15:0] CHAR_B = 16'h0042;
   localparam logic [15:0] CHAR_C = 16'h0043;
   localparam logic [15:0] CHAR_D = 16'h0044;

   localparam logic [15:0] CU_NONE      = 16'h0000;
   localparam logic [15:0] CU_BACKSPACE = 16'h0008;
   localparam logic [15:0] CU_ASCII_END = 16'h0080;
   localparam logic [15:0] CODE_DEL     = 16'h007F;

   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] CP_TWO_BYTE_END = 21'h000800;
   localparam logic [20:0] CP_BMP_END      = 21'h010000;

   localparam logic [15:0] HOME_CODE_RESET   = 16'd256;
   localparam logic [15:0] DELETE_CODE_RESET = 16'd257;

   // Register index, taken from address bit 2.
   localparam logic CSR_HOME_IDX   = 1'b0;
   localparam logic CSR_DELETE_IDX = 1'b1;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One decoded event: count of codes to emit (0 to 4), first code in slot 0.
   typedef struct packed {
      logic [2:0]        count;
      logic [3:0][15:0]  codes;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

### sv/key_event_to_utf8_bytes.sv
// Converts console key events into result codes: arrow letters, the configured
// Home and Delete codes, ASCII, or the UTF-8 bytes of the typed character, with
// surrogate pairs joined across two events. An event is accepted in every cycle
// while the command queue (QUEUE_DEPTH entries) has room; events that give no
// result, including a held high surrogate, never enter the queue. The result
// side delivers one beat per cycle while pop is held and results wait in the
// queue; an event gives one to four results. The first result of an event
// passes through its queue entry and the output register to the result ports,
// if nothing ahead of it waits. Registers: home_key_code at address 0 and
// delete_key_code at address 4, 16 bits each in the low half of the data word.
module key_event_to_utf8_bytes #(
   parameter int QUEUE_DEPTH = ke2u8_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_is_key_event,
   input  logic        req_key_down,
   input  logic [7:0]  req_virtual_key,
   input  logic [15:0] req_code_unit,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_key_code,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ke2u8_pkg::*;

   logic           in_fire;
   logic           q_push;
   logic           q_pop;
   logic           csr_write;
   cmd_type        cmd;
   queue_head_type head;
   logic [15:0]    home_code_ff;
   logic [15:0]    delete_code_ff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = {16'd0, (paddr[2] == CSR_DELETE_IDX) ? delete_code_ff : home_code_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         home_code_ff   <= HOME_CODE_RESET;
         delete_code_ff <= DELETE_CODE_RESET;
      end else if (csr_write) begin
         if (paddr[2] == CSR_HOME_IDX) begin
            home_code_ff <= pwdata[15:0];
         end else begin
            delete_code_ff <= pwdata[15:0];
         end
      end
   end

   assign in_fire = push && !full;
   assign q_push  = in_fire && (cmd.count != 3'd0);

   ke2u8_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (in_fire),
      .is_key_event    (req_is_key_event),
      .key_down        (req_key_down),
      .virtual_key     (req_virtual_key),
      .code_unit       (req_code_unit),
      .home_key_code   (home_code_ff),
      .delete_key_code (delete_code_ff),
      .cmd             (cmd)
   );

   ke2u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (cmd),
      .full     (full),
      .pop      (q_pop),
      .head     (head)
   );

   ke2u8_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_key_code (rsp_key_code),
      .rsp_last     (rsp_last)
   );

endmodule

### sv/ke2u8_front.sv
`include "key_event_to_utf8_bytes_macros.svh"

module ke2u8_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               is_key_event,
   input  logic               key_down,
   input  logic [7:0]         virtual_key,
   input  logic [15:0]        code_unit,
   input  logic [15:0]        home_key_code,
   input  logic [15:0]        delete_key_code,
   output ke2u8_pkg::cmd_type cmd
);
   import ke2u8_pkg::*;

   logic [15:0] held_ff;
   logic [15:0] held_in;
   logic [20:0] cp;
   logic        use_utf8;
   logic        is_high;
   logic        is_low;
   logic        takes_high;

   assign is_high = (code_unit >= HIGH_SURR_FIRST) && (code_unit <= HIGH_SURR_LAST);
   assign is_low  = (code_unit >= LOW_SURR_FIRST) && (code_unit <= LOW_SURR_LAST);

   // A pressed high surrogate on a key outside the navigation set is stored.
   assign takes_high = is_key_event && key_down && is_high
                       && (virtual_key != HOME_VKEY) && (virtual_key != DELETE_VKEY)
                       && ((virtual_key < LEFT_VKEY) || (virtual_key > DOWN_VKEY));

   always_comb begin
      cmd.count = 3'd0;
      cmd.codes = '0;
      held_in   = held_ff;
      cp        = '0;
      use_utf8  = 1'b0;
      if (is_key_event && key_down) begin
         case (virtual_key)
            UP_VKEY: begin
               cmd.count    = 3'd1;
               cmd.codes[0] = CHAR_A;
            end
            DOWN_VKEY: begin
               cmd.count    = 3'd1;
               cmd.codes[0] = CHAR_B;
            end
            RIGHT_VKEY: begin
               cmd.count    = 3'd1;
               cmd.codes[0] = CHAR_C;
            end
            LEFT_VKEY: begin
               cmd.count    = 3'd1;
               cmd.codes[0] = CHAR_D;
            end
            HOME_VKEY: begin
               cmd.count    = 3'd1;
               cmd.codes[0] = home_key_code;
            end
            DELETE_VKEY: begin
               cmd.count    = 3'd1;
               cmd.codes[0] = delete_key_code;
            end
            default: begin
               if (code_unit == CU_NONE) begin
                  cmd.count = 3'd0;
               end else if (code_unit == CU_BACKSPACE) begin
                  cmd.count    = 3'd1;
                  cmd.codes[0] = CODE_DEL;
               end else if (code_unit < CU_ASCII_END) begin
                  cmd.count    = 3'd1;
                  cmd.codes[0] = code_unit;
               end else if (is_high) begin
                  held_in = code_unit;
               end else if (is_low) begin
                  use_utf8 = 1'b1;
                  if (held_ff != 16'd0) begin
                     // The ten payload bits of each half sit side by side above 0x10000.
                     cp      = CP_BMP_END + {1'b0, held_ff[9:0], code_unit[9:0]};
                     held_in = 16'd0;
                  end else begin
                     cp = CP_REPLACEMENT;
                  end
               end else begin
                  use_utf8 = 1'b1;
                  cp       = {5'd0, code_unit};
               end
            end
         endcase
      end

      if (use_utf8) begin
         if (cp < CP_TWO_BYTE_END) begin
            cmd.count    = 3'd2;
            cmd.codes[0] = {8'h00, 3'b110, cp[10:6]};
            cmd.codes[1] = {8'h00, 2'b10, cp[5:0]};
         end else if (cp < CP_BMP_END) begin
            cmd.count    = 3'd3;
            cmd.codes[0] = {8'h00, 4'b1110, cp[15:12]};
            cmd.codes[1] = {8'h00, 2'b10, cp[11:6]};
            cmd.codes[2] = {8'h00, 2'b10, cp[5:0]};
         end else begin
            cmd.count    = 3'd4;
            cmd.codes[0] = {8'h00, 5'b11110, cp[20:18]};
            cmd.codes[1] = {8'h00, 2'b10, cp[17:12]};
            cmd.codes[2] = {8'h00, 2'b10, cp[11:6]};
            cmd.codes[3] = {8'h00, 2'b10, cp[5:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 16'd0;
      end else if (accept) begin
         held_ff <= held_in;
      end
   end

   `KE_ASSERT_NEXT(a_high_surrogate_held, accept && takes_high, held_ff == $past(code_unit))

endmodule

### sv/ke2u8_queue.sv
`include "key_event_to_utf8_bytes_macros.svh"

module ke2u8_queue #(
   parameter int DEPTH = ke2u8_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ke2u8_pkg::cmd_type        push_cmd,
   output logic                      full,
   input  logic                      pop,
   output ke2u8_pkg::queue_head_type head
);
   import ke2u8_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         entries_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `KE_ASSERT_ALWAYS(a_no_push_when_full, !(push && full))
   `KE_ASSERT_ALWAYS(a_no_pop_when_empty, !(pop && !head.valid))

endmodule

### sv/ke2u8_back.sv
`include "key_event_to_utf8_bytes_macros.svh"

module ke2u8_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ke2u8_pkg::queue_head_type head,
   output logic                      q_pop,
   input  logic                      pop,
   output logic                      empty,
   output logic [15:0]               rsp_key_code,
   output logic                      rsp_last
);
   import ke2u8_pkg::*;

   logic [1:0]  idx_ff;
   logic [1:0]  idx_in;
   logic        valid_ff;
   logic        valid_in;
   logic [15:0] code_ff;
   logic [15:0] code_in;
   logic        last_ff;
   logic        last_in;
   logic        pop_fire;
   logic        load;
   logic        is_last;

   assign pop_fire = pop && valid_ff;
   // The output register takes a new beat when it is free or being emptied.
   assign load     = head.valid && (!valid_ff || pop_fire);
   assign is_last  = ({1'b0, idx_ff} == (head.cmd.count - 3'd1));
   assign q_pop    = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      code_in  = code_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         code_in  = head.cmd.codes[idx_ff];
         last_in  = is_last;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (pop_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign empty        = !valid_ff;
   assign rsp_key_code = code_ff;
   assign rsp_last     = last_ff;

   `KE_ASSERT_ALWAYS(a_index_within_count, !head.valid || ({1'b0, idx_ff} < head.cmd.count))

endmodule
